FILE: hw/rtl/rtnh_pkg.sv
// Shared types and constants for the ray/triangle nearest-hit block.
// Holds payload structs, controller-to-datapath command struct and the
// multiply-accumulate sequence table. No dependencies.
package rtnh_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int FRAC_BITS    = 16;
  localparam int TRI_ID_WIDTH = 20;

  localparam int T_WIDTH  = COORD_WIDTH - 1;
  localparam int UV_WIDTH = FRAC_BITS + 1;

  // edge / offset width, cross product width, dot product width
  localparam int EW = COORD_WIDTH + 1;
  localparam int XW = 2 * COORD_WIDTH + 2;
  localparam int DW = 3 * COORD_WIDTH + 5;

  // serial multiplier: DIG bits of the narrow operand per cycle
  localparam int MUL_DIG   = 16;
  localparam int MUL_STEPS = (EW + MUL_DIG - 1) / MUL_DIG;
  localparam int AW_PAD    = MUL_STEPS * MUL_DIG;
  localparam int PW        = XW + AW_PAD;
  localparam int MCW       = $clog2(MUL_STEPS + 1);

  // divider
  localparam int QW_MAX = (T_WIDTH > UV_WIDTH) ? T_WIDTH : UV_WIDTH;
  localparam int DVW    = DW + QW_MAX + FRAC_BITS;
  localparam int DCW    = $clog2(QW_MAX + 1);

  // threshold compare width
  localparam int GW = DW + 2 * FRAC_BITS + T_WIDTH;

  localparam int NUM_OPS  = 24;
  localparam int OP_IDX_W = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_WIDTH;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PAR_THR  = 3'd7;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] v0_x;
    logic signed [COORD_WIDTH-1:0] v0_y;
    logic signed [COORD_WIDTH-1:0] v0_z;
    logic signed [COORD_WIDTH-1:0] v1_x;
    logic signed [COORD_WIDTH-1:0] v1_y;
    logic signed [COORD_WIDTH-1:0] v1_z;
    logic signed [COORD_WIDTH-1:0] v2_x;
    logic signed [COORD_WIDTH-1:0] v2_y;
    logic signed [COORD_WIDTH-1:0] v2_z;
    logic [TRI_ID_WIDTH-1:0]       tri_id;
    logic                          last_tri;
  } in_item_t;

  typedef struct packed {
    logic                    tri_hit;
    logic [T_WIDTH-1:0]      tri_t;
    logic [UV_WIDTH-1:0]     tri_u;
    logic [UV_WIDTH-1:0]     tri_v;
    logic                    best_found;
    logic [T_WIDTH-1:0]      best_t;
    logic [UV_WIDTH-1:0]     best_u;
    logic [UV_WIDTH-1:0]     best_v;
    logic [TRI_ID_WIDTH-1:0] best_id;
    logic                    ray_done;
  } out_item_t;

  typedef enum logic [3:0] {
    ASEL_E1X, ASEL_E1Y, ASEL_E1Z,
    ASEL_E2X, ASEL_E2Y, ASEL_E2Z,
    ASEL_SX,  ASEL_SY,  ASEL_SZ,
    ASEL_DX,  ASEL_DY,  ASEL_DZ
  } a_sel_t;

  typedef enum logic [3:0] {
    BSEL_DX,  BSEL_DY,  BSEL_DZ,
    BSEL_E1X, BSEL_E1Y, BSEL_E1Z,
    BSEL_PX,  BSEL_PY,  BSEL_PZ,
    BSEL_QX,  BSEL_QY,  BSEL_QZ
  } b_sel_t;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_PX, DST_PY, DST_PZ,
    DST_QX, DST_QY, DST_QZ,
    DST_DET, DST_UN, DST_VN, DST_TN
  } dest_t;

  typedef enum logic [1:0] {
    DIV_T, DIV_U, DIV_V
  } div_sel_t;

  typedef struct packed {
    a_sel_t a;
    b_sel_t b;
    logic   sub;
    logic   first;
    dest_t  dst;
  } mac_op_t;

  typedef struct packed {
    logic     load_item;
    logic     prep;
    logic     mac_load;
    logic     mul_step;
    logic     mac_acc;
    mac_op_t  op;
    logic     chk_prep;
    logic     chk_eval;
    logic     div_start;
    logic     div_step;
    logic     div_save;
    div_sel_t div_sel;
    logic     finish;
  } dp_cmd_t;

  // Multiply-accumulate sequence: P = D x E2, det = E1.P, Q = S x E1,
  // un = S.P, vn = D.Q, tn = E2.Q
  function automatic mac_op_t mac_op(input logic [OP_IDX_W-1:0] idx);
    mac_op_t m;
    unique case (idx)
      5'd0:  m = '{ASEL_E2Z, BSEL_DY,  1'b0, 1'b1, DST_NONE};
      5'd1:  m = '{ASEL_E2Y, BSEL_DZ,  1'b1, 1'b0, DST_PX};
      5'd2:  m = '{ASEL_E2X, BSEL_DZ,  1'b0, 1'b1, DST_NONE};
      5'd3:  m = '{ASEL_E2Z, BSEL_DX,  1'b1, 1'b0, DST_PY};
      5'd4:  m = '{ASEL_E2Y, BSEL_DX,  1'b0, 1'b1, DST_NONE};
      5'd5:  m = '{ASEL_E2X, BSEL_DY,  1'b1, 1'b0, DST_PZ};
      5'd6:  m = '{ASEL_E1X, BSEL_PX,  1'b0, 1'b1, DST_NONE};
      5'd7:  m = '{ASEL_E1Y, BSEL_PY,  1'b0, 1'b0, DST_NONE};
      5'd8:  m = '{ASEL_E1Z, BSEL_PZ,  1'b0, 1'b0, DST_DET};
      5'd9:  m = '{ASEL_SY,  BSEL_E1Z, 1'b0, 1'b1, DST_NONE};
      5'd10: m = '{ASEL_SZ,  BSEL_E1Y, 1'b1, 1'b0, DST_QX};
      5'd11: m = '{ASEL_SZ,  BSEL_E1X, 1'b0, 1'b1, DST_NONE};
      5'd12: m = '{ASEL_SX,  BSEL_E1Z, 1'b1, 1'b0, DST_QY};
      5'd13: m = '{ASEL_SX,  BSEL_E1Y, 1'b0, 1'b1, DST_NONE};
      5'd14: m = '{ASEL_SY,  BSEL_E1X, 1'b1, 1'b0, DST_QZ};
      5'd15: m = '{ASEL_SX,  BSEL_PX,  1'b0, 1'b1, DST_NONE};
      5'd16: m = '{ASEL_SY,  BSEL_PY,  1'b0, 1'b0, DST_NONE};
      5'd17: m = '{ASEL_SZ,  BSEL_PZ,  1'b0, 1'b0, DST_UN};
      5'd18: m = '{ASEL_DX,  BSEL_QX,  1'b0, 1'b1, DST_NONE};
      5'd19: m = '{ASEL_DY,  BSEL_QY,  1'b0, 1'b0, DST_NONE};
      5'd20: m = '{ASEL_DZ,  BSEL_QZ,  1'b0, 1'b0, DST_VN};
      5'd21: m = '{ASEL_E2X, BSEL_QX,  1'b0, 1'b1, DST_NONE};
      5'd22: m = '{ASEL_E2Y, BSEL_QY,  1'b0, 1'b0, DST_NONE};
      5'd23: m = '{ASEL_E2Z, BSEL_QZ,  1'b0, 1'b0, DST_TN};
      default: m = '{ASEL_E1X, BSEL_DX, 1'b0, 1'b1, DST_NONE};
    endcase
    return m;
  endfunction

endpackage

FILE: hw/rtl/rtnh_ctrl.sv
// Sequencer for the nearest-hit block: steps the datapath through edge
// prep, the multiply-accumulate program, hit checks and three divisions.
// Depends on rtnh_pkg.
module rtnh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rtnh_pkg::dp_cmd_t cmd
);
  import rtnh_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_MLOAD, ST_MUL, ST_MACC, ST_CHK_PREP, ST_CHK_EVAL,
    ST_DIV_START, ST_DIV_STEP, ST_DIV_SAVE, ST_DONE
  } state_t;

  state_t                state_r;
  logic [OP_IDX_W-1:0]   op_idx_r;
  logic [MCW-1:0]        mul_cnt_r;
  logic [DCW-1:0]        div_cnt_r;
  div_sel_t              div_sel_r;
  logic                  out_valid_r;
  logic [DCW-1:0]        div_last;
  logic                  can_finish;

  assign div_last   = (div_sel_r == DIV_T) ? DCW'(T_WIDTH - 1) : DCW'(UV_WIDTH - 1);
  assign can_finish = !out_valid_r || out_ready;
  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;

  // Decode commands from state
  always_comb begin
    cmd           = '0;
    cmd.op        = mac_op(op_idx_r);
    cmd.div_sel   = div_sel_r;
    cmd.load_item = (state_r == ST_IDLE) && in_valid;
    cmd.prep      = (state_r == ST_PREP);
    cmd.mac_load  = (state_r == ST_MLOAD);
    cmd.mul_step  = (state_r == ST_MUL);
    cmd.mac_acc   = (state_r == ST_MACC);
    cmd.chk_prep  = (state_r == ST_CHK_PREP);
    cmd.chk_eval  = (state_r == ST_CHK_EVAL);
    cmd.div_start = (state_r == ST_DIV_START);
    cmd.div_step  = (state_r == ST_DIV_STEP);
    cmd.div_save  = (state_r == ST_DIV_SAVE);
    cmd.finish    = (state_r == ST_DONE) && can_finish;
  end

  // Hold state, counters and the result-valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_idx_r    <= '0;
      mul_cnt_r   <= '0;
      div_cnt_r   <= '0;
      div_sel_r   <= DIV_T;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) state_r <= ST_PREP;
        end
        ST_PREP: begin
          op_idx_r <= '0;
          state_r  <= ST_MLOAD;
        end
        ST_MLOAD: begin
          mul_cnt_r <= '0;
          state_r   <= ST_MUL;
        end
        ST_MUL: begin
          mul_cnt_r <= mul_cnt_r + 1'b1;
          if (mul_cnt_r == MCW'(MUL_STEPS - 1)) state_r <= ST_MACC;
        end
        ST_MACC: begin
          if (op_idx_r == OP_IDX_W'(NUM_OPS - 1)) begin
            state_r <= ST_CHK_PREP;
          end else begin
            op_idx_r <= op_idx_r + 1'b1;
            state_r  <= ST_MLOAD;
          end
        end
        ST_CHK_PREP: state_r <= ST_CHK_EVAL;
        ST_CHK_EVAL: begin
          div_sel_r <= DIV_T;
          state_r   <= ST_DIV_START;
        end
        ST_DIV_START: begin
          div_cnt_r <= '0;
          state_r   <= ST_DIV_STEP;
        end
        ST_DIV_STEP: begin
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == div_last) state_r <= ST_DIV_SAVE;
        end
        ST_DIV_SAVE: begin
          priority if (div_sel_r == DIV_V) begin
            state_r <= ST_DONE;
          end else if (div_sel_r == DIV_T) begin
            div_sel_r <= DIV_U;
            state_r   <= ST_DIV_START;
          end else begin
            div_sel_r <= DIV_V;
            state_r   <= ST_DIV_START;
          end
        end
        ST_DONE: begin
          if (can_finish) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/rtnh_datapath.sv
// Datapath for the nearest-hit block: ray registers, edge vectors, serial
// multiply-accumulate, restoring divider, nearest store and result register.
// Depends on rtnh_pkg; driven by rtnh_ctrl.
module rtnh_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rtnh_pkg::dp_cmd_t                   cmd,
  input  rtnh_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  logic [rtnh_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [rtnh_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output rtnh_pkg::out_item_t                 out_data
);
  import rtnh_pkg::*;

  localparam int CW = COORD_WIDTH;

  // ray configuration
  logic signed [CW-1:0] org_x_r, org_y_r, org_z_r;
  logic signed [CW-1:0] dir_x_r, dir_y_r, dir_z_r;
  logic [T_WIDTH-1:0]   min_dist_r, thr_r;

  // item and derived vectors
  in_item_t             item_r;
  logic signed [EW-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r, sx_r, sy_r, sz_r;
  logic signed [XW-1:0] px_r, py_r, pz_r, qx_r, qy_r, qz_r;
  logic signed [DW-1:0] det_r, un_r, vn_r, tn_r, acc_r;

  // multiplier
  logic [AW_PAD-1:0]    mag_a_r;
  logic [XW-1:0]        mag_b_r;
  logic                 neg_r;
  logic [PW-1:0]        prod_r;

  // checks and divider
  logic [DW-1:0]        absdet_r, unn_r, vnn_r, tnn_r;
  logic                 pass_r;
  logic [DVW-1:0]       num_r, den_r;
  logic [QW_MAX-1:0]    q_r;
  logic [T_WIDTH-1:0]   t_r;
  logic [UV_WIDTH-1:0]  u_r, v_r;

  // nearest store and result
  logic                    nv_r;
  logic [T_WIDTH-1:0]      nd_r;
  logic [UV_WIDTH-1:0]     nu_r, nvv_r;
  logic [TRI_ID_WIDTH-1:0] nt_r;
  out_item_t               out_r;

  logic signed [EW-1:0] a_val;
  logic signed [XW-1:0] b_val;
  logic [EW-1:0]        a_abs;
  logic [XW-1:0]        b_abs;
  logic [XW+MUL_DIG-1:0] pp;
  logic [DW-1:0]        term;
  logic signed [DW-1:0] acc_sum;
  logic [DW-1:0]        div_src;
  logic                 div_ge;
  logic                 hit, upd;
  logic [GW-1:0]        thr_ext;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r    <= '0;
      org_y_r    <= '0;
      org_z_r    <= '0;
      dir_x_r    <= '0;
      dir_y_r    <= '0;
      dir_z_r    <= CW'(1) << FRAC_BITS;
      min_dist_r <= T_WIDTH'(1);
      thr_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ORIGIN_X: org_x_r    <= cfg_wdata;
        REG_ORIGIN_Y: org_y_r    <= cfg_wdata;
        REG_ORIGIN_Z: org_z_r    <= cfg_wdata;
        REG_DIR_X:    dir_x_r    <= cfg_wdata;
        REG_DIR_Y:    dir_y_r    <= cfg_wdata;
        REG_DIR_Z:    dir_z_r    <= cfg_wdata;
        REG_MIN_DIST: min_dist_r <= cfg_wdata[T_WIDTH-1:0];
        REG_PAR_THR:  thr_r      <= cfg_wdata[T_WIDTH-1:0];
      endcase
    end
  end

  // Select multiplier operands
  always_comb begin
    unique case (cmd.op.a)
      ASEL_E1X: a_val = e1x_r;
      ASEL_E1Y: a_val = e1y_r;
      ASEL_E1Z: a_val = e1z_r;
      ASEL_E2X: a_val = e2x_r;
      ASEL_E2Y: a_val = e2y_r;
      ASEL_E2Z: a_val = e2z_r;
      ASEL_SX:  a_val = sx_r;
      ASEL_SY:  a_val = sy_r;
      ASEL_SZ:  a_val = sz_r;
      ASEL_DX:  a_val = EW'(dir_x_r);
      ASEL_DY:  a_val = EW'(dir_y_r);
      ASEL_DZ:  a_val = EW'(dir_z_r);
      default:  a_val = '0;
    endcase
    unique case (cmd.op.b)
      BSEL_DX:  b_val = XW'(dir_x_r);
      BSEL_DY:  b_val = XW'(dir_y_r);
      BSEL_DZ:  b_val = XW'(dir_z_r);
      BSEL_E1X: b_val = XW'(e1x_r);
      BSEL_E1Y: b_val = XW'(e1y_r);
      BSEL_E1Z: b_val = XW'(e1z_r);
      BSEL_PX:  b_val = px_r;
      BSEL_PY:  b_val = py_r;
      BSEL_PZ:  b_val = pz_r;
      BSEL_QX:  b_val = qx_r;
      BSEL_QY:  b_val = qy_r;
      BSEL_QZ:  b_val = qz_r;
      default:  b_val = '0;
    endcase
  end

  assign a_abs   = a_val[EW-1] ? EW'(-a_val) : EW'(a_val);
  assign b_abs   = b_val[XW-1] ? XW'(-b_val) : XW'(b_val);
  assign pp      = (XW + MUL_DIG)'(mag_b_r) * (XW + MUL_DIG)'(mag_a_r[AW_PAD-1 -: MUL_DIG]);
  assign term    = prod_r[DW-1:0];
  assign acc_sum = (cmd.op.first ? DW'(0) : acc_r) +
                   ((neg_r ^ cmd.op.sub) ? DW'(-term) : term);
  assign thr_ext = GW'(thr_r) << (2 * FRAC_BITS);
  assign div_ge  = (den_r <= num_r);

  always_comb begin
    unique case (cmd.div_sel)
      DIV_T:   div_src = tnn_r;
      DIV_U:   div_src = unn_r;
      DIV_V:   div_src = vnn_r;
      default: div_src = '0;
    endcase
  end

  assign hit = pass_r && (t_r >= min_dist_r);
  assign upd = hit && (!nv_r || (t_r < nd_r));

  // Edge prep, multiply-accumulate, checks and divider
  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
    if (cmd.prep) begin
      e1x_r <= EW'(item_r.v1_x) - EW'(item_r.v0_x);
      e1y_r <= EW'(item_r.v1_y) - EW'(item_r.v0_y);
      e1z_r <= EW'(item_r.v1_z) - EW'(item_r.v0_z);
      e2x_r <= EW'(item_r.v2_x) - EW'(item_r.v0_x);
      e2y_r <= EW'(item_r.v2_y) - EW'(item_r.v0_y);
      e2z_r <= EW'(item_r.v2_z) - EW'(item_r.v0_z);
      sx_r  <= EW'(org_x_r) - EW'(item_r.v0_x);
      sy_r  <= EW'(org_y_r) - EW'(item_r.v0_y);
      sz_r  <= EW'(org_z_r) - EW'(item_r.v0_z);
    end
    // latch magnitudes, then shift in one digit of A per cycle
    if (cmd.mac_load) begin
      mag_a_r <= AW_PAD'(a_abs);
      mag_b_r <= b_abs;
      neg_r   <= a_val[EW-1] ^ b_val[XW-1];
      prod_r  <= '0;
    end
    if (cmd.mul_step) begin
      prod_r  <= (prod_r << MUL_DIG) + PW'(pp);
      mag_a_r <= mag_a_r << MUL_DIG;
    end
    if (cmd.mac_acc) begin
      acc_r <= acc_sum;
      unique case (cmd.op.dst)
        DST_PX:  px_r  <= acc_sum[XW-1:0];
        DST_PY:  py_r  <= acc_sum[XW-1:0];
        DST_PZ:  pz_r  <= acc_sum[XW-1:0];
        DST_QX:  qx_r  <= acc_sum[XW-1:0];
        DST_QY:  qy_r  <= acc_sum[XW-1:0];
        DST_QZ:  qz_r  <= acc_sum[XW-1:0];
        DST_DET: det_r <= acc_sum;
        DST_UN:  un_r  <= acc_sum;
        DST_VN:  vn_r  <= acc_sum;
        DST_TN:  tn_r  <= acc_sum;
        default: ;
      endcase
    end
    // fold the determinant sign into the numerators
    if (cmd.chk_prep) begin
      absdet_r <= det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
      unn_r    <= det_r[DW-1] ? DW'(-un_r) : DW'(un_r);
      vnn_r    <= det_r[DW-1] ? DW'(-vn_r) : DW'(vn_r);
      tnn_r    <= det_r[DW-1] ? DW'(-tn_r) : DW'(tn_r);
    end
    if (cmd.chk_eval) begin
      pass_r <= (GW'(absdet_r) > thr_ext) &&
                !unn_r[DW-1] && !vnn_r[DW-1] && !tnn_r[DW-1] &&
                (unn_r <= absdet_r) &&
                (((DW + 1)'(unn_r) + (DW + 1)'(vnn_r)) <= (DW + 1)'(absdet_r));
    end
    // restoring divide, one quotient bit per cycle from the top
    if (cmd.div_start) begin
      num_r <= DVW'(div_src) << FRAC_BITS;
      q_r   <= '0;
      priority if (cmd.div_sel == DIV_T) den_r <= DVW'(absdet_r) << (T_WIDTH - 1);
      else den_r <= DVW'(absdet_r) << (UV_WIDTH - 1);
    end
    if (cmd.div_step) begin
      if (div_ge) num_r <= num_r - den_r;
      den_r <= den_r >> 1;
      q_r   <= {q_r[QW_MAX-2:0], div_ge};
    end
    if (cmd.div_save) begin
      unique case (cmd.div_sel)
        DIV_T:   t_r <= q_r[T_WIDTH-1:0];
        DIV_U:   u_r <= q_r[UV_WIDTH-1:0];
        DIV_V:   v_r <= q_r[UV_WIDTH-1:0];
        default: ;
      endcase
    end
    // build the result from the updated nearest store
    if (cmd.finish) begin
      out_r.tri_hit    <= hit;
      out_r.tri_t      <= hit ? t_r : '0;
      out_r.tri_u      <= hit ? u_r : '0;
      out_r.tri_v      <= hit ? v_r : '0;
      out_r.best_found <= nv_r || upd;
      out_r.best_t     <= upd ? t_r : nd_r;
      out_r.best_u     <= upd ? u_r : nu_r;
      out_r.best_v     <= upd ? v_r : nvv_r;
      out_r.best_id    <= upd ? item_r.tri_id : nt_r;
      out_r.ray_done   <= item_r.last_tri;
    end
  end

  // Nearest-hit store; the last triangle of a ray clears it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r  <= 1'b0;
      nd_r  <= '1;
      nu_r  <= '0;
      nvv_r <= '0;
      nt_r  <= '0;
    end else if (cmd.finish) begin
      if (item_r.last_tri) begin
        nv_r  <= 1'b0;
        nd_r  <= '1;
        nu_r  <= '0;
        nvv_r <= '0;
        nt_r  <= '0;
      end else if (upd) begin
        nv_r  <= 1'b1;
        nd_r  <= t_r;
        nu_r  <= u_r;
        nvv_r <= v_r;
        nt_r  <= item_r.tri_id;
      end
    end
  end

  assign out_data = out_r;

endmodule

FILE: hw/rtl/ray_triangle_nearest_hit.sv
// Ray/triangle nearest-hit engine (Moller-Trumbore in exact fixed point).
// Input channel (in_valid/in_ready/in_data): one triangle per transaction,
// three signed Q16.16 vertices, a triangle id and a last-triangle flag.
// Output channel (out_valid/out_ready/out_data): one result per triangle
// with this triangle's hit, t, u, v and the running nearest hit; the
// result of the last triangle carries the final nearest hit and clears
// the store for the next ray.
// Configuration port (cfg_we/cfg_addr/cfg_wdata): ray origin, direction,
// minimum distance and parallel threshold; write only while idle.
// Timing: one triangle is processed at a time; the next is accepted once the
// last result has entered the output register. The work per triangle is 24
// serial multiply-accumulates, each over 3 16-bit digits of the narrow operand,
// plus 65 restoring divide steps for t, u and v.
// A finished result waits in the output register; the next triangle is
// accepted meanwhile, and if the receiver still stalls when that one is
// done, the engine holds it until the output register frees.
// Reset (synchronous, active low) loads the default ray, empties the
// nearest-hit store and clears the output valid flag.
module ray_triangle_nearest_hit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rtnh_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rtnh_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [rtnh_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [rtnh_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import rtnh_pkg::*;

  dp_cmd_t cmd;

  rtnh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  rtnh_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

  // engine goes busy after taking a triangle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("engine took a triangle while busy");

  // a miss reports zero t, u and v
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.tri_hit) |->
      (out_data.tri_t == '0 && out_data.tri_u == '0 && out_data.tri_v == '0))
    else $error("miss result carries nonzero t/u/v");

  // empty nearest store reads as its cleared value
  a_empty_best: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.best_found) |->
      (out_data.best_t == {T_WIDTH{1'b1}} && out_data.best_id == '0))
    else $error("empty nearest store shows a hit");

endmodule
